### rtl/ppmr_pkg.sv
// ----------------------------------------------------------------------------
// ppmr_pkg
// Types, codes and reset values shared by the power-line PPM frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ppmr_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // event kinds on the input channel
    localparam logic EV_CROSSING = 1'b0;
    localparam logic EV_PULSE    = 1'b1;

    localparam logic [7:0] FRAME_DIBITS = 8'd16;

    localparam logic [15:0] RST_WINDOW_BASE    = 16'd48000;
    localparam logic [11:0] RST_WINDOW_STEP    = 12'd1000;
    localparam logic [11:0] RST_WINDOW_LOW     = 12'd100;
    localparam logic [11:0] RST_WINDOW_HIGH    = 12'd1100;
    localparam logic [15:0] RST_MIN_HALF_CYCLE = 16'd59000;
    localparam logic [7:0]  RST_SYNC_BYTE      = 8'd150;
    localparam logic [7:0]  RST_MODULE_ADDRESS = 8'd228;

    typedef enum logic [2:0] {
        REG_WINDOW_BASE    = 3'd0,
        REG_WINDOW_STEP    = 3'd1,
        REG_WINDOW_LOW     = 3'd2,
        REG_WINDOW_HIGH    = 3'd3,
        REG_MIN_HALF_CYCLE = 3'd4,
        REG_SYNC_BYTE      = 3'd5,
        REG_MODULE_ADDRESS = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] window_base;
        logic [11:0] window_step;
        logic [11:0] window_low;
        logic [11:0] window_high;
        logic [15:0] min_half_cycle;
        logic [7:0]  sync_byte;
        logic [7:0]  module_address;
    } t_cfg;

endpackage

`default_nettype wire

### rtl/ppmr_if.sv
// ----------------------------------------------------------------------------
// ppmr_in_if / ppmr_out_if
// Valid/ready channels for input events and frame results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppmr_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] elapsed;

    modport source (output valid, output cmd, output elapsed, input ready);
    modport sink   (input valid, input cmd, input elapsed, output ready);
endinterface

interface ppmr_out_if;
    logic       valid;
    logic       ready;
    logic       restart_timer;
    logic       edge_select;
    logic       frame_done;
    logic       to_me;
    logic [7:0] dest_addr;
    logic [7:0] src_addr;
    logic [7:0] command;

    modport source (output valid, output restart_timer, output edge_select,
                    output frame_done, output to_me, output dest_addr,
                    output src_addr, output command, input ready);
    modport sink   (input valid, input restart_timer, input edge_select,
                    input frame_done, input to_me, input dest_addr,
                    input src_addr, input command, output ready);
endinterface

`default_nettype wire

### rtl/powerline_ppm_frame_receiver.sv
// An event enters the input register at its transfer; the result register,
// which drives the valid result, loads from it once the result side advances.
// Throughput: one event per cycle while the result side accepts every cycle;
// a stalled result holds the input register, then the input side stalls.
// Reset (synchronous, active low) clears the channels and the receive state
// and loads the register defaults; the four frame bytes are not cleared.
// ----------------------------------------------------------------------------
// powerline_ppm_frame_receiver
// Pulse-position frame receiver for mains power-line signaling.
// ----------------------------------------------------------------------------
`default_nettype none

module powerline_ppm_frame_receiver (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ppmr_in_if.sink                             i_ev,
    ppmr_out_if.source                          o_res,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ppmr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ppmr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ppmr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import ppmr_pkg::*;

    t_cfg w_cfg;

    ppmr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ppmr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_ev    (i_ev),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

### rtl/ppmr_window.sv
// ----------------------------------------------------------------------------
// ppmr_window
// Pulse position decode: tests the elapsed count against four windows.
// ----------------------------------------------------------------------------
`default_nettype none

module ppmr_window (
    input  ppmr_pkg::t_cfg i_cfg,
    input  logic [15:0]    i_elapsed,
    output logic           o_hit,
    output logic [1:0]     o_pos
);
    import ppmr_pkg::*;

    // all bounds fit in 17 bits: 65535 + 3*4095 + 4095
    always_comb begin
        logic [16:0] centre;
        logic [16:0] lo;
        logic [16:0] hi;
        logic [16:0] e;
        o_hit = 1'b0;
        o_pos = 2'd0;
        e     = {1'b0, i_elapsed};
        for (int k = 0; k < 4; k++) begin
            centre = {1'b0, i_cfg.window_base}
                   + 17'({5'd0, i_cfg.window_step} * 17'(k));
            lo = centre + {5'd0, i_cfg.window_low};
            hi = centre + {5'd0, i_cfg.window_high};
            // later positions override earlier ones
            if (lo < e && e < hi) begin
                o_hit = 1'b1;
                o_pos = 2'(k);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/ppmr_cfg.sv
// ----------------------------------------------------------------------------
// ppmr_cfg
// APB register file holding the window, timing, sync and address settings.
// ----------------------------------------------------------------------------
`default_nettype none

module ppmr_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ppmr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ppmr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ppmr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output ppmr_pkg::t_cfg                      o_cfg
);
    import ppmr_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_base    <= RST_WINDOW_BASE;
            r_cfg.window_step    <= RST_WINDOW_STEP;
            r_cfg.window_low     <= RST_WINDOW_LOW;
            r_cfg.window_high    <= RST_WINDOW_HIGH;
            r_cfg.min_half_cycle <= RST_MIN_HALF_CYCLE;
            r_cfg.sync_byte      <= RST_SYNC_BYTE;
            r_cfg.module_address <= RST_MODULE_ADDRESS;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_WINDOW_BASE:    r_cfg.window_base    <= pwdata[15:0];
                REG_WINDOW_STEP:    r_cfg.window_step    <= pwdata[11:0];
                REG_WINDOW_LOW:     r_cfg.window_low     <= pwdata[11:0];
                REG_WINDOW_HIGH:    r_cfg.window_high    <= pwdata[11:0];
                REG_MIN_HALF_CYCLE: r_cfg.min_half_cycle <= pwdata[15:0];
                REG_SYNC_BYTE:      r_cfg.sync_byte      <= pwdata[7:0];
                REG_MODULE_ADDRESS: r_cfg.module_address <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WINDOW_BASE:    prdata = {16'd0, r_cfg.window_base};
            REG_WINDOW_STEP:    prdata = {20'd0, r_cfg.window_step};
            REG_WINDOW_LOW:     prdata = {20'd0, r_cfg.window_low};
            REG_WINDOW_HIGH:    prdata = {20'd0, r_cfg.window_high};
            REG_MIN_HALF_CYCLE: prdata = {16'd0, r_cfg.min_half_cycle};
            REG_SYNC_BYTE:      prdata = {24'd0, r_cfg.sync_byte};
            REG_MODULE_ADDRESS: prdata = {24'd0, r_cfg.module_address};
            default:            prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/ppmr_core.sv
// ----------------------------------------------------------------------------
// ppmr_core
// Input register, receive state update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppmr_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ppmr_pkg::t_cfg i_cfg,
    ppmr_in_if.sink        i_ev,
    ppmr_out_if.source     o_res
);
    import ppmr_pkg::*;

    // input stage
    logic        r_in_valid;
    logic        r_cmd;
    logic [15:0] r_elapsed;

    // receive state
    logic            r_recv, n_recv;
    logic            r_taken, n_taken;
    logic            r_pol, n_pol;
    logic [7:0]      r_hc, n_hc;
    logic [7:0]      r_ec, n_ec;
    logic [2:0]      r_di, n_di;
    logic [2:0]      r_bi, n_bi;
    logic [3:0][7:0] r_frame, n_frame;

    // result stage
    logic       r_out_valid;
    logic       r_restart, n_restart;
    logic       r_done, n_done;
    logic       r_to_me, n_to_me;
    logic [7:0] r_dest, n_dest;
    logic [7:0] r_src, n_src;
    logic [7:0] r_command, n_command;

    logic       w_adv;
    logic       w_hit;
    logic [1:0] w_pos;

    assign w_adv      = !r_out_valid || o_res.ready;
    assign i_ev.ready = !r_in_valid || w_adv;

    ppmr_window u_window (
        .i_cfg     (i_cfg),
        .i_elapsed (r_elapsed),
        .o_hit     (w_hit),
        .o_pos     (w_pos)
    );

    always_comb begin
        logic [2:0] bi_m1;
        logic [2:0] slot_m1;
        logic [7:0] dib;
        logic [7:0] sync_sh;
        n_recv    = r_recv;
        n_taken   = r_taken;
        n_pol     = r_pol;
        n_hc      = r_hc;
        n_ec      = r_ec;
        n_di      = r_di;
        n_bi      = r_bi;
        n_frame   = r_frame;
        n_restart = 1'b0;
        n_done    = 1'b0;
        bi_m1     = 3'd0;
        slot_m1   = 3'd0;
        dib       = 8'd0;
        sync_sh   = 8'd0;

        if (r_cmd == EV_CROSSING) begin
            if (r_elapsed > i_cfg.min_half_cycle) begin
                n_restart = 1'b1;
                n_pol     = !r_pol;
                n_hc      = r_hc + 8'd1;
                n_taken   = 1'b0;
            end
        end else if (!r_taken && w_hit) begin
            n_taken = 1'b1;
            if (!r_recv) begin
                // open a new frame
                n_recv = 1'b1;
                n_hc   = 8'd1;
                n_ec   = 8'd0;
                n_di   = 3'd1;
                n_bi   = 3'd1;
            end else begin
                n_di = r_di + 3'd1;
            end

            if ({1'b0, n_ec} + 9'd1 == {1'b0, n_hc}) begin
                bi_m1   = n_bi - 3'd1;
                slot_m1 = n_di - 3'd1;
                dib     = {6'd0, w_pos} << {slot_m1[1:0], 1'b0};
                sync_sh = i_cfg.sync_byte >> {slot_m1[1:0], 1'b0};
                if (n_di != 3'd0 && n_di <= 3'd4) begin
                    if (n_bi != 3'd0 && n_bi <= 3'd4) begin
                        if (n_di == 3'd1) begin
                            n_frame[bi_m1[1:0]] = dib;
                        end else begin
                            n_frame[bi_m1[1:0]] = n_frame[bi_m1[1:0]] | dib;
                        end
                    end
                    // sync byte is checked one dibit at a time
                    if (n_bi == 3'd1 && w_pos != sync_sh[1:0]) begin
                        n_recv = 1'b0;
                    end
                    if (n_di == 3'd4) begin
                        n_bi = n_bi + 3'd1;
                        n_di = 3'd0;
                    end
                end
                if (n_hc == FRAME_DIBITS) begin
                    n_done = 1'b1;
                    n_recv = 1'b0;
                end
                n_ec = n_ec + 8'd1;
            end else begin
                // missed half-cycle: drop the frame
                n_recv = 1'b0;
            end
        end

        if (n_done) begin
            n_to_me   = (n_frame[1] == i_cfg.module_address);
            n_dest    = n_frame[1];
            n_src     = n_frame[2];
            n_command = n_frame[3];
        end else begin
            n_to_me   = 1'b0;
            n_dest    = 8'd0;
            n_src     = 8'd0;
            n_command = 8'd0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_recv      <= 1'b0;
            r_taken     <= 1'b0;
            r_pol       <= 1'b0;
            r_hc        <= 8'd0;
            r_ec        <= 8'd0;
            r_di        <= 3'd0;
            r_bi        <= 3'd1;
        end else begin
            if (i_ev.ready) begin
                r_in_valid <= i_ev.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_recv  <= n_recv;
                    r_taken <= n_taken;
                    r_pol   <= n_pol;
                    r_hc    <= n_hc;
                    r_ec    <= n_ec;
                    r_di    <= n_di;
                    r_bi    <= n_bi;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ev.ready && i_ev.valid) begin
            r_cmd     <= i_ev.cmd;
            r_elapsed <= i_ev.elapsed;
        end
        if (w_adv && r_in_valid) begin
            r_frame   <= n_frame;
            r_restart <= n_restart;
            r_done    <= n_done;
            r_to_me   <= n_to_me;
            r_dest    <= n_dest;
            r_src     <= n_src;
            r_command <= n_command;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.restart_timer = r_restart;
    assign o_res.edge_select   = r_pol;
    assign o_res.frame_done    = r_done;
    assign o_res.to_me         = r_to_me;
    assign o_res.dest_addr     = r_dest;
    assign o_res.src_addr      = r_src;
    assign o_res.command       = r_command;

endmodule

`default_nettype wire

### rtl/ppmr_checker.sv
// ----------------------------------------------------------------------------
// ppmr_checker
// Port-level checks on the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ppmr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_restart,
    input logic       i_edge,
    input logic       i_done,
    input logic       i_to_me,
    input logic [7:0] i_dest,
    input logic [7:0] i_src,
    input logic [7:0] i_command
);

    // a frame completes only on a pulse, never on a crossing
    a_done_not_crossing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done |-> !i_restart)
        else $error("frame_done together with restart_timer");

    // frame fields stay zero outside a completed frame
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_done |-> !i_to_me && i_dest == 8'd0
                                   && i_src == 8'd0 && i_command == 8'd0)
        else $error("frame fields set without frame_done");

    // with the result side empty the input side never stalls
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_restart)
                                        && $stable(i_edge) && $stable(i_done)
                                        && $stable(i_dest))
        else $error("stalled result changed");

endmodule

bind powerline_ppm_frame_receiver ppmr_checker u_ppmr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_ev.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_restart   (o_res.restart_timer),
    .i_edge      (o_res.edge_select),
    .i_done      (o_res.frame_done),
    .i_to_me     (o_res.to_me),
    .i_dest      (o_res.dest_addr),
    .i_src       (o_res.src_addr),
    .i_command   (o_res.command)
);

`default_nettype wire
